>>> rtl/core/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int SEND_DEPTH = 32;
  localparam int SEND_AW    = $clog2(SEND_DEPTH);
  localparam int RX_SPAN    = 32;
  localparam int POS_W      = 6;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_START_WR = 2'd1,
    OP_START_RD = 2'd2,
    OP_STATUS   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_START    = 3'd1,
    ACT_SEND     = 3'd2,
    ACT_RX_ACK   = 3'd3,
    ACT_RX_NACK  = 3'd4,
    ACT_STOP     = 3'd5,
    ACT_RELEASE  = 3'd6,
    ACT_RST_STOP = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  localparam logic [7:0] ST_BUS_ERR   = 8'h00;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATW_ACK  = 8'h28;
  localparam logic [7:0] ST_DATW_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_DATR_ACK  = 8'h50;
  localparam logic [7:0] ST_DATR_NACK = 8'h58;
  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

  typedef struct packed {
    op_e        operation;
    logic [4:0] slot;
    logic [7:0] byte_value;
    logic [7:0] device_address;
    logic [5:0] transfer_length;
    logic [7:0] bus_status;
  } in_t;

  typedef struct packed {
    act_e       bus_action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] rx_position;
    logic       busy_res;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [SEND_AW-1:0] addr;
    logic [7:0]         data;
  } st_wr_t;

endpackage

>>> rtl/core/i2c_master_transaction_sequencer_core.sv
`timescale 1ns / 1ps
// i2c master transaction sequencer
// slave stream carries host requests: loads into the send store, write or
// read starts, and bus status events with the byte just received
// master stream carries one result per request: the bus action, the byte
// to send, a delivered received byte with its position, busy and rejected
// each request is registered on entry, decoded against the sequencer state
// and registered again on the way out; its result is presented on the
// master side from that result register and is taken there
// one request per cycle is taken while the master side keeps up; the only
// loop is the state update of the sequencer registers, closed within the decode
// when the master side stalls, the result register holds and the entry
// register fills, after which s_axis_tready drops until the result is taken
// reset clears both stages and returns the sequencer to idle with zeroed
// counters and address; the send store is not cleared and holds whatever
// was loaded last
module i2c_master_transaction_sequencer_core
  import i2cms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot, byte_value, device_address, transfer_length, bus_status, zero pad
  input  logic [39:0] s_axis_tdata,
  // operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_action, tx_byte, rx_byte, rx_position, busy_res, rejected, zero pad
  output logic [31:0] m_axis_tdata,
  // rx_valid
  output logic        m_axis_tuser
);

  in_t                s_item;
  in_t                item;
  res_t               res;
  res_t               m_res;
  logic               fire;
  st_wr_t             st_wr;
  logic [SEND_AW-1:0] rd_addr;
  logic [7:0]         rd_data;

  always_comb begin
    s_item.operation       = op_e'(s_axis_tuser);
    s_item.slot            = s_axis_tdata[4:0];
    s_item.byte_value      = s_axis_tdata[12:5];
    s_item.device_address  = s_axis_tdata[20:13];
    s_item.transfer_length = s_axis_tdata[26:21];
    s_item.bus_status      = s_axis_tdata[34:27];
  end

  i2cms_top_io u_io (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .fire_o    (fire),
    .item_o    (item),
    .res_i     (res),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (m_res)
  );

  i2cms_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .wr_o      (st_wr),
    .res_o     (res)
  );

  i2cms_store u_store (
    .clk_i     (clk_i),
    .wr_i      (st_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tdata = {6'd0, m_res.rejected, m_res.busy_res, m_res.rx_position,
                         m_res.rx_byte, m_res.tx_byte, m_res.bus_action};
  assign m_axis_tuser = m_res.rx_valid;

endmodule

>>> rtl/core/i2cms_store.sv
`timescale 1ns / 1ps

module i2cms_store
  import i2cms_pkg::*;
(
  input  logic               clk_i,
  input  st_wr_t             wr_i,
  input  logic [SEND_AW-1:0] rd_addr_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0] mem_q [SEND_DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.we && (wr_i.addr == rd_addr_i)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> rtl/core/i2cms_seq.sv
`timescale 1ns / 1ps

module i2cms_seq
  import i2cms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  in_t                item_i,
  input  logic [7:0]         rd_data_i,
  output logic [SEND_AW-1:0] rd_addr_o,
  output st_wr_t             wr_o,
  output res_t               res_o
);

  mode_e            mode_q, mode_d;
  logic [7:0]       addr_q, addr_d;
  logic [POS_W-1:0] spos_q, spos_d;
  logic [POS_W-1:0] scnt_q, scnt_d;
  logic [POS_W-1:0] rpos_q, rpos_d;
  logic [POS_W-1:0] rcnt_q, rcnt_d;

  logic [7:0]       status;
  act_e             ack_act;
  act_e             ack_take;
  logic [POS_W-1:0] rpos_inc;
  logic             rx_take;

  assign status    = item_i.bus_status & ST_MASK;
  // next send position, so the store has the byte ready at the next decode
  assign rd_addr_o = fire_i ? spos_d[SEND_AW-1:0] : spos_q[SEND_AW-1:0];
  assign rpos_inc  = (rpos_q != '1) ? rpos_q + POS_W'(1) : rpos_q;
  assign ack_act   = ({1'b0, rpos_q} + 7'd1 < {1'b0, rcnt_q}) ? ACT_RX_ACK : ACT_RX_NACK;
  assign ack_take  = ({1'b0, rpos_inc} + 7'd1 < {1'b0, rcnt_q}) ? ACT_RX_ACK : ACT_RX_NACK;

  always_comb begin
    wr_o.we   = fire_i && (item_i.operation == OP_LOAD) && (32'(item_i.slot) < SEND_DEPTH);
    wr_o.addr = item_i.slot[SEND_AW-1:0];
    wr_o.data = item_i.byte_value;
  end

  always_comb begin
    mode_d  = mode_q;
    addr_d  = addr_q;
    spos_d  = spos_q;
    scnt_d  = scnt_q;
    rpos_d  = rpos_q;
    rcnt_d  = rcnt_q;
    rx_take = 1'b0;
    res_o   = '0;
    res_o.bus_action = ACT_NONE;
    case (item_i.operation)
      OP_LOAD: begin
      end
      OP_START_WR, OP_START_RD: begin
        if (mode_q != MODE_IDLE) begin
          res_o.rejected = 1'b1;
        end else if (item_i.operation == OP_START_WR) begin
          mode_d = MODE_WRITE;
          addr_d = item_i.device_address & ADDR_WR_MASK;
          spos_d = '0;
          scnt_d = (32'(item_i.transfer_length) > SEND_DEPTH) ? POS_W'(SEND_DEPTH)
                                                              : item_i.transfer_length;
          res_o.bus_action = ACT_START;
        end else begin
          mode_d = MODE_READ;
          addr_d = item_i.device_address | ADDR_RD_BIT;
          rpos_d = '0;
          rcnt_d = item_i.transfer_length;
          res_o.bus_action = ACT_START;
        end
      end
      default: begin
        case (status)
          ST_START, ST_RESTART: begin
            res_o.bus_action = ACT_SEND;
            res_o.tx_byte    = addr_q;
          end
          ST_SLAW_ACK, ST_DATW_ACK: begin
            if (spos_q < scnt_q && 32'(spos_q) < SEND_DEPTH) begin
              res_o.bus_action = ACT_SEND;
              res_o.tx_byte    = rd_data_i;
              spos_d           = spos_q + POS_W'(1);
            end else begin
              res_o.bus_action = ACT_STOP;
              mode_d           = MODE_IDLE;
            end
          end
          ST_DATR_NACK: begin
            rx_take          = 1'b1;
            res_o.bus_action = ACT_STOP;
            mode_d           = MODE_IDLE;
          end
          ST_SLAW_NACK, ST_DATW_NACK, ST_SLAR_NACK: begin
            res_o.bus_action = ACT_STOP;
            mode_d           = MODE_IDLE;
          end
          ST_ARB_LOST: begin
            res_o.bus_action = ACT_RELEASE;
            mode_d           = MODE_IDLE;
          end
          ST_DATR_ACK: begin
            rx_take          = 1'b1;
            res_o.bus_action = ack_take;
          end
          ST_SLAR_ACK: begin
            res_o.bus_action = ack_act;
          end
          ST_BUS_ERR: begin
            res_o.bus_action = ACT_RST_STOP;
            mode_d           = MODE_IDLE;
          end
          default: begin
          end
        endcase
      end
    endcase
    if (rx_take) begin
      if (32'(rpos_q) < RX_SPAN) begin
        res_o.rx_valid    = 1'b1;
        res_o.rx_byte     = item_i.byte_value;
        res_o.rx_position = rpos_q[4:0];
      end
      rpos_d = rpos_inc;
    end
    res_o.busy_res = (mode_d != MODE_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      addr_q <= '0;
      spos_q <= '0;
      scnt_q <= '0;
      rpos_q <= '0;
      rcnt_q <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      addr_q <= addr_d;
      spos_q <= spos_d;
      scnt_q <= scnt_d;
      rpos_q <= rpos_d;
      rcnt_q <= rcnt_d;
    end
  end

endmodule

>>> rtl/core/i2cms_top_io.sv
`timescale 1ns / 1ps

module i2cms_top_io
  import i2cms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  in_t         s_item_i,
  output logic        fire_o,
  output in_t         item_o,
  input  res_t        res_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output res_t        m_res_o
);

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  res_t out_q;
  logic adv;

  assign adv       = !out_valid_q || m_ready_i;
  assign fire_o    = in_valid_q && adv;
  assign s_ready_o = !in_valid_q || adv;
  assign item_o    = in_q;
  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_ready_o) begin
        in_valid_q <= s_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_q <= s_item_i;
    end
    if (fire_o) begin
      out_q <= res_i;
    end
  end

endmodule
